// ----- rtl/msim_pkg.sv -----
package msim_pkg;

  localparam int NUM_SENSORS       = 8;
  localparam int SAMPLE_WIDTH      = 32;
  localparam int LIMITS_PER_SENSOR = 6;

  // field widths of the request and result channels
  localparam int REQ_W    = 3;
  localparam int IDX_W    = 3;
  localparam int SAMPLE_W = 32;
  localparam int DT_W     = 16;
  localparam int BAND_W   = 2;
  localparam int LEVEL_W  = 2;
  localparam int STAMP_W  = 32;

  // stored and compared width: low bits of the sample
  localparam int VAL_W  = (SAMPLE_WIDTH < 32) ? SAMPLE_WIDTH : 32;
  localparam int SENS_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int LANE_W = $clog2(LIMITS_PER_SENSOR);

  localparam logic [STAMP_W-1:0] CLOCK_MAX = '1;

  localparam logic [BAND_W-1:0] BAND_WARN  = 2'd0;
  localparam logic [BAND_W-1:0] BAND_STOP  = 2'd1;
  localparam logic [BAND_W-1:0] BAND_FAULT = 2'd2;

  localparam logic SIDE_LOW  = 1'b0;
  localparam logic SIDE_HIGH = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_UPDATE      = 3'd0,
    REQ_ACK         = 3'd1,
    REQ_RESET_ESTOP = 3'd2,
    REQ_CLEAR_ALL   = 3'd3,
    REQ_LOAD_LIMIT  = 3'd4
  } req_type_t;

  typedef enum logic [LEVEL_W-1:0] {
    LVL_OK    = 2'd0,
    LVL_WARN  = 2'd1,
    LVL_STOP  = 2'd2,
    LVL_FAULT = 2'd3
  } level_t;

endpackage

// ----- rtl/msim_if.sv -----
interface msim_in_if;
  logic                                valid;
  logic                                ready;
  logic        [msim_pkg::REQ_W-1:0]   req_type;
  logic        [msim_pkg::IDX_W-1:0]   sensor_index;
  logic signed [msim_pkg::SAMPLE_W-1:0] sample_value;
  logic        [msim_pkg::DT_W-1:0]    elapsed_ms;
  logic        [msim_pkg::BAND_W-1:0]  band_select;
  logic                                side_select;
  logic                                limit_enable;

  modport source (output valid, req_type, sensor_index, sample_value, elapsed_ms,
                  band_select, side_select, limit_enable, input ready);
  modport sink   (input valid, req_type, sensor_index, sample_value, elapsed_ms,
                  band_select, side_select, limit_enable, output ready);
endinterface

interface msim_out_if;
  logic                                valid;
  logic                                ready;
  logic [msim_pkg::LEVEL_W-1:0]        sensor_level;
  logic                                record_valid;
  logic [msim_pkg::STAMP_W-1:0]        stamp_ms;
  logic [msim_pkg::LEVEL_W-1:0]        overall_level;
  logic                                estop_out;
  logic                                run_permitted;

  modport source (output valid, sensor_level, record_valid, stamp_ms, overall_level,
                  estop_out, run_permitted, input ready);
  modport sink   (input valid, sensor_level, record_valid, stamp_ms, overall_level,
                  estop_out, run_permitted, output ready);
endinterface

// ----- rtl/multi_sensor_interlock_monitor.sv -----
// Interlock monitor for a fixed set of sensors. Every request returns exactly one
// result, in order: an update classifies a signed Q20.12 sample against the
// sensor's enabled warn/stop/fault limits (strict compares, most severe hit wins),
// records the sensor's alarm level, latches e-stop on a fault and advances a
// saturating millisecond clock by elapsed_ms; acknowledge, reset e-stop, clear
// all and load limit are the other request types, and codes five to seven only
// report status. Each result carries the clock, the worst active level over all
// sensors, the e-stop latch and the run permit. The block takes one request per
// clock unless the result side stalls; the request and the sensor's row of six
// limits from the limit memory are registered first (a load still in flight to
// the same row is forwarded); stage 2 then classifies, updates the alarm state
// and fills the result register. Limit values are undefined until loaded, but
// a limit is compared only once its enable bit, cleared by reset, has been set.
module multi_sensor_interlock_monitor (
  input  logic       clk,
  input  logic       rst_n,
  msim_in_if.sink    in_chan,
  msim_out_if.source out_chan
);
  import msim_pkg::*;

  // handshake and pipeline control
  logic s2_v_r;
  logic out_v_r;
  logic s2_fire;
  logic in_acc;

  // request register (stage 2)
  req_type_t                s2_req_r;
  logic [IDX_W-1:0]         s2_idx_r;
  logic signed [VAL_W-1:0]  s2_val_r;
  logic [DT_W-1:0]          s2_dt_r;
  logic [BAND_W-1:0]        s2_band_r;
  logic                     s2_side_r;
  logic                     s2_en_r;
  logic signed [VAL_W-1:0]  row_r [LIMITS_PER_SENSOR];

  // limit store (one row of six lanes per sensor) and alarm state
  logic [LIMITS_PER_SENSOR-1:0][VAL_W-1:0] lim_mem [NUM_SENSORS];
  logic [LIMITS_PER_SENSOR-1:0]  en_r [NUM_SENSORS];
  level_t                        lvl_r [NUM_SENSORS];
  logic                          estop_r;
  logic [STAMP_W-1:0]            clock_r;

  // stage 2 combinational results
  level_t              lvl_nxt [NUM_SENSORS];
  logic                estop_nxt;
  logic [STAMP_W-1:0]  clock_nxt;
  level_t              cls;
  level_t              item_lvl;
  level_t              ovr;
  logic                known;
  logic [SENS_W-1:0]   srow;
  logic [LANE_W-1:0]   slane;
  logic [STAMP_W:0]    clock_sum;
  logic                wr_en;
  logic [NUM_SENSORS-1:0] has_fault, has_stop, has_warn;
  logic [SENS_W-1:0]   in_row;

  // result register
  level_t              res_lvl_r;
  logic                res_rec_r;
  logic [STAMP_W-1:0]  res_stamp_r;
  level_t              res_ovr_r;
  logic                res_estop_r;
  logic                res_run_r;

  assign s2_fire       = s2_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready = !s2_v_r || s2_fire;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign in_row        = SENS_W'(in_chan.sensor_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s2_v_r <= 1'b1;
      end else if (s2_fire) begin
        s2_v_r <= 1'b0;
      end
      if (s2_fire) begin
        out_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // stage 1: capture the request and read the sensor's limit row
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s2_req_r  <= req_type_t'(in_chan.req_type);
      s2_idx_r  <= in_chan.sensor_index;
      s2_val_r  <= in_chan.sample_value[VAL_W-1:0];
      s2_dt_r   <= in_chan.elapsed_ms;
      s2_band_r <= in_chan.band_select;
      s2_side_r <= in_chan.side_select;
      s2_en_r   <= in_chan.limit_enable;
      for (int j = 0; j < LIMITS_PER_SENSOR; j++) begin
        // bypass a load that writes this row at the same edge
        if (wr_en && srow == in_row && slane == LANE_W'(j)) begin
          row_r[j] <= s2_val_r;
        end else begin
          row_r[j] <= lim_mem[in_row][j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lim_mem[srow][slane] <= s2_val_r;
    end
  end

  // stage 2: classify and work out the next alarm state
  assign known     = 32'(s2_idx_r) < NUM_SENSORS;
  assign srow      = SENS_W'(s2_idx_r);
  assign slane     = LANE_W'({s2_band_r, s2_side_r});
  assign clock_sum = {1'b0, clock_r} + {{(STAMP_W + 1 - DT_W){1'b0}}, s2_dt_r};

  always_comb begin
    cls = LVL_OK;
    // bands in rising order so the most severe hit wins
    for (int b = 0; b < 3; b++) begin
      if ((en_r[srow][LANE_W'(2 * b)] && (s2_val_r < row_r[LANE_W'(2 * b)])) ||
          (en_r[srow][LANE_W'(2 * b + 1)] &&
           (s2_val_r > row_r[LANE_W'(2 * b + 1)]))) begin
        cls = level_t'(LEVEL_W'(b + 1));
      end
    end
  end

  always_comb begin
    lvl_nxt   = lvl_r;
    clock_nxt = clock_r;
    item_lvl  = LVL_OK;
    wr_en     = 1'b0;
    unique case (s2_req_r)
      REQ_UPDATE: begin
        if (known) begin
          clock_nxt     = clock_sum[STAMP_W] ? CLOCK_MAX : clock_sum[STAMP_W-1:0];
          item_lvl      = cls;
          lvl_nxt[srow] = cls;
        end
      end
      REQ_ACK: begin
        if (known) begin
          lvl_nxt[srow] = LVL_OK;
        end
      end
      REQ_CLEAR_ALL: begin
        for (int i = 0; i < NUM_SENSORS; i++) begin
          lvl_nxt[i] = LVL_OK;
        end
        clock_nxt = '0;
      end
      REQ_LOAD_LIMIT: begin
        wr_en = s2_fire && known && (s2_band_r <= BAND_FAULT);
      end
      default: begin
      end
    endcase
  end

  // worst level over all sensors after this request
  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      has_fault[i] = (lvl_nxt[i] == LVL_FAULT);
      has_stop[i]  = (lvl_nxt[i] == LVL_STOP);
      has_warn[i]  = (lvl_nxt[i] == LVL_WARN);
    end
    priority if (|has_fault) begin
      ovr = LVL_FAULT;
    end else if (|has_stop) begin
      ovr = LVL_STOP;
    end else if (|has_warn) begin
      ovr = LVL_WARN;
    end else begin
      ovr = LVL_OK;
    end
  end

  always_comb begin
    estop_nxt = estop_r;
    unique case (s2_req_r)
      REQ_UPDATE: begin
        if (item_lvl == LVL_FAULT) begin
          estop_nxt = 1'b1;
        end
      end
      REQ_ACK: begin
        if (ovr == LVL_OK) begin
          estop_nxt = 1'b0;
        end
      end
      REQ_RESET_ESTOP: begin
        if (ovr != LVL_FAULT) begin
          estop_nxt = 1'b0;
        end
      end
      REQ_CLEAR_ALL: begin
        estop_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // state commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        en_r[i]  <= '0;
        lvl_r[i] <= LVL_OK;
      end
      estop_r <= 1'b0;
      clock_r <= '0;
    end else if (s2_fire) begin
      lvl_r   <= lvl_nxt;
      estop_r <= estop_nxt;
      clock_r <= clock_nxt;
      if (wr_en) begin
        en_r[srow][slane] <= s2_en_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (s2_fire) begin
      res_lvl_r   <= item_lvl;
      res_rec_r   <= (item_lvl != LVL_OK);
      res_stamp_r <= clock_nxt;
      res_ovr_r   <= ovr;
      res_estop_r <= estop_nxt;
      res_run_r   <= !estop_nxt && (ovr != LVL_STOP) && (ovr != LVL_FAULT);
    end
  end

  assign out_chan.valid         = out_v_r;
  assign out_chan.sensor_level  = res_lvl_r;
  assign out_chan.record_valid  = res_rec_r;
  assign out_chan.stamp_ms      = res_stamp_r;
  assign out_chan.overall_level = res_ovr_r;
  assign out_chan.estop_out     = res_estop_r;
  assign out_chan.run_permitted = res_run_r;

`ifndef SYNTH
  // a fault level anywhere can only exist with the e-stop latched
  a_fault_implies_estop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && res_ovr_r == LVL_FAULT) |-> res_estop_r)
    else $error("fault reported without e-stop latched");

  // the latch drops only through acknowledge, reset e-stop or clear all
  a_estop_release: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(estop_r)) |->
      $past(s2_fire && (s2_req_r == REQ_ACK || s2_req_r == REQ_RESET_ESTOP ||
                        s2_req_r == REQ_CLEAR_ALL)))
    else $error("e-stop released by an unexpected request");

  // the clock never runs backward except on clear all
  a_clock_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (clock_r < $past(clock_r))) |->
      $past(s2_fire && s2_req_r == REQ_CLEAR_ALL))
    else $error("millisecond clock went backward");
`endif

endmodule
